// File: rtl/dtns_pkg.sv
// Package: shared types, constants and the fraction weight table for the number scanner.
package dtns_pkg;

  localparam int INT_BITS        = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 5;

  // integer magnitude register is at least 4 bits so a single leading digit always fits
  localparam int ACC_W = (INT_BITS - 1 < 4) ? 4 : INT_BITS - 1;
  localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int MAG_W = ACC_W + FRAC_BITS;

  localparam logic [ACC_W-1:0]     IMAX = ACC_W'((64'd1 << (INT_BITS - 1)) - 64'd1);
  localparam logic [FRAC_BITS-1:0] FMAX = '1;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // round(2^FRAC_BITS / 10^k), half up, for k = 1..9
  localparam logic [63:0] TWO_F1 = 64'd1 << (FRAC_BITS + 1);
  localparam logic [63:0] FW1 = (TWO_F1 / 64'd10 + 64'd1) / 64'd2;
  localparam logic [63:0] FW2 = (TWO_F1 / 64'd100 + 64'd1) / 64'd2;
  localparam logic [63:0] FW3 = (TWO_F1 / 64'd1000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW4 = (TWO_F1 / 64'd10000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW5 = (TWO_F1 / 64'd100000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW6 = (TWO_F1 / 64'd1000000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW7 = (TWO_F1 / 64'd10000000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW8 = (TWO_F1 / 64'd100000000 + 64'd1) / 64'd2;
  localparam logic [63:0] FW9 = (TWO_F1 / 64'd1000000000 + 64'd1) / 64'd2;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_MINUS = 2'd1,
    MODE_INT   = 2'd2,
    MODE_FRAC  = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [31:0] number_value;
    logic        number_found;
    logic        saturated_flag;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } core_out_t;

  typedef struct packed {
    logic [QCW-1:0] cnt;
  } q_stat_t;

  // weight of the fraction digit at position idx (0 = first after the point)
  function automatic logic [FRAC_BITS-1:0] frac_weight(input logic [3:0] idx);
    logic [63:0] w;
    unique case (idx)
      4'd0:    w = FW1;
      4'd1:    w = FW2;
      4'd2:    w = FW3;
      4'd3:    w = FW4;
      4'd4:    w = FW5;
      4'd5:    w = FW6;
      4'd6:    w = FW7;
      4'd7:    w = FW8;
      4'd8:    w = FW9;
      default: w = 64'd0;
    endcase
    return w[FRAC_BITS-1:0];
  endfunction

endpackage

// File: rtl/decimal_text_number_scanner_unit.sv
// Top level: input register, scanner core and result queue of the decimal number scanner.
// One character word is accepted per clock unless the result queue stalls the core. A character is
// held in the input register and parsed there combinationally; the resulting words (none, one, or two
// for a zero byte that closes a pending number) enter a four-word result queue that drives the
// out_ ports, so a result passes the input register and the queue before it appears. The core
// advances whenever the queue holds at most two words; with a result consumer that is always
// ready the rate is one character per cycle, and each zero byte that follows a number adds one
// extra output word. Values are signed Q16.16 with the integer part clamped at 32767.
module decimal_text_number_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_number_value,
  output logic        out_number_found,
  output logic        out_saturated_flag,
  output logic        out_last_of_run
);
  import dtns_pkg::*;

  logic       in_v_r;
  logic [7:0] char_r;
  logic       fire;
  core_out_t  core_res;
  res_t       head;
  q_stat_t    qstat;

  // parse only when the queue has room for two words
  assign fire     = in_v_r && (qstat.cnt <= QCW'(QDEPTH - 2));
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) char_r <= in_char_code;
  end

  dtns_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .char_code (char_r),
    .res       (core_res)
  );

  dtns_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (core_res),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .stat       (qstat)
  );

  assign out_number_value   = head.number_value;
  assign out_number_found   = head.number_found;
  assign out_saturated_flag = head.saturated_flag;
  assign out_last_of_run    = head.last_of_run;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.cnt <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_pair_ends_eol: assert property (@(posedge clk) disable iff (!rst_n)
    fire && core_res.n == 2'd2 |->
      !core_res.r1.number_found && core_res.r1.last_of_run && !core_res.r0.last_of_run)
    else $error("two-word result not number then end-of-line");

  a_eol_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_number_found |->
      out_last_of_run && !out_saturated_flag && out_number_value == 32'd0)
    else $error("malformed end-of-line word");
`endif

endmodule

// File: rtl/dtns_core.sv
// Scanner core: number state registers and the per-character parse step.
module dtns_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          char_code,
  output dtns_pkg::core_out_t res
);
  import dtns_pkg::*;

  scan_mode_t           mode_r, mode_nxt;
  logic                 neg_r, neg_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [FRAC_BITS-1:0] fs_r, fs_nxt;
  logic [CNT_W-1:0]     fcnt_r, fcnt_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 digit;
  logic [3:0]           dval;
  logic [ACC_W+3:0]     int_sum;
  logic                 int_over;
  logic [FRAC_BITS+4:0] frac_sum;
  logic [63:0]          mag64;
  logic [31:0]          mag32;
  logic [31:0]          val;
  res_t                 num_w;
  res_t                 eol_w;

  assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dval  = 4'(char_code - CH_ZERO);

  // acc*10 + d as shift-adds
  assign int_sum  = (ACC_W+4)'({acc_r, 3'b000}) + (ACC_W+4)'({acc_r, 1'b0}) +
                    (ACC_W+4)'(dval);
  assign int_over = int_sum > (ACC_W+4)'(IMAX);

  assign frac_sum = (FRAC_BITS+5)'(fs_r) +
                    (FRAC_BITS+5)'(dval) * (FRAC_BITS+5)'(frac_weight(4'(fcnt_r)));

  // fraction is below 2^FRAC_BITS, so the magnitude is a plain concatenation
  assign mag64 = 64'({acc_r, fs_r});
  assign mag32 = mag64[31:0];
  assign val   = neg_r ? (~mag32 + 32'd1) : mag32;

  assign num_w = '{number_value: val, number_found: 1'b1,
                   saturated_flag: ovf_r, last_of_run: 1'b1};
  assign eol_w = '{number_value: 32'd0, number_found: 1'b0,
                   saturated_flag: 1'b0, last_of_run: 1'b1};

  always_comb begin
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    fs_nxt   = fs_r;
    fcnt_nxt = fcnt_r;
    ovf_nxt  = ovf_r;
    res      = '0;
    if (char_code == CH_NUL) begin
      if (mode_r == MODE_INT || mode_r == MODE_FRAC) begin
        res.r0             = num_w;
        res.r0.last_of_run = 1'b0;
        res.r1             = eol_w;
        res.n              = 2'd2;
      end else begin
        res.r0 = eol_w;
        res.n  = 2'd1;
      end
      mode_nxt = MODE_IDLE;
      neg_nxt  = 1'b0;
      acc_nxt  = '0;
      fs_nxt   = '0;
      fcnt_nxt = '0;
      ovf_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (digit) begin
            mode_nxt = MODE_INT;
            acc_nxt  = ACC_W'(dval);
          end else if (char_code == CH_MINUS) begin
            mode_nxt = MODE_MINUS;
            neg_nxt  = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (digit) begin
            mode_nxt = MODE_INT;
            acc_nxt  = ACC_W'(dval);
          end else if (char_code != CH_MINUS) begin
            mode_nxt = MODE_IDLE;
            neg_nxt  = 1'b0;
          end
        end
        MODE_INT, MODE_FRAC: begin
          if (digit) begin
            if (mode_r == MODE_INT) begin
              acc_nxt = int_over ? IMAX : int_sum[ACC_W-1:0];
              ovf_nxt = ovf_r | int_over;
            end else if (fcnt_r < CNT_W'(MAX_FRAC_DIGITS)) begin
              fs_nxt   = (frac_sum > (FRAC_BITS+5)'(FMAX)) ? FMAX
                                                          : frac_sum[FRAC_BITS-1:0];
              fcnt_nxt = fcnt_r + CNT_W'(1);
            end
          end else if (mode_r == MODE_INT && char_code == CH_POINT) begin
            mode_nxt = MODE_FRAC;
            fcnt_nxt = '0;
          end else begin
            // terminator: emit, then rescan it from idle (only '-' starts anything)
            res.r0   = num_w;
            res.n    = 2'd1;
            acc_nxt  = '0;
            fs_nxt   = '0;
            fcnt_nxt = '0;
            ovf_nxt  = 1'b0;
            if (char_code == CH_MINUS) begin
              mode_nxt = MODE_MINUS;
              neg_nxt  = 1'b1;
            end else begin
              mode_nxt = MODE_IDLE;
              neg_nxt  = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      fs_r   <= '0;
      fcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      neg_r  <= neg_nxt;
      acc_r  <= acc_nxt;
      fs_r   <= fs_nxt;
      fcnt_r <= fcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// File: rtl/dtns_outq.sv
// Result queue: takes up to two words per cycle, hands out one word per cycle while the consumer is ready.
module dtns_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dtns_pkg::core_out_t push_data,
  input  logic                pop_ready,
  output logic                head_valid,
  output dtns_pkg::res_t      head,
  output dtns_pkg::q_stat_t   stat
);
  import dtns_pkg::*;

  res_t           q_r [QDEPTH];
  logic [QPW-1:0] wp_r, wp_nxt;
  logic [QPW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     push_n;
  logic           pop;

  assign push_n     = push ? push_data.n : 2'd0;
  assign head_valid = cnt_r != '0;
  assign pop        = head_valid && pop_ready;
  assign head       = q_r[rp_r];
  assign stat.cnt   = cnt_r;

  assign wp_nxt  = wp_r + QPW'(push_n);
  assign rp_nxt  = rp_r + QPW'(pop);
  assign cnt_nxt = cnt_r + QCW'(push_n) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wp_r] <= push_data.r0;
    if (push_n == 2'd2) q_r[wp_r + QPW'(1)] <= push_data.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
